### hw/rtl/ffpa_pkg.sv
`timescale 1ns / 1ps

package ffpa_pkg;

  // Size of the page table
  localparam int PAGE_FRAMES = 16;

  localparam int IDX_W   = (PAGE_FRAMES > 1) ? $clog2(PAGE_FRAMES) : 1;
  localparam int CNT_W   = $clog2(PAGE_FRAMES + 1);
  localparam int OWNER_W = 8;
  localparam int ENTRY_W = OWNER_W + 1;   // {used, owner}
  localparam int MASK_W  = 16;
  localparam int DONE_W  = 5;
  localparam int WANT_W  = 5;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [DONE_W-1:0] pages_done;
    logic [MASK_W-1:0] page_mask;
  } result_t;

  typedef struct packed {
    logic               cmd;
    logic [OWNER_W-1:0] owner_id;
    logic [WANT_W-1:0]  page_count;
  } request_t;

endpackage

### hw/rtl/ffpa_ram.sv
`timescale 1ns / 1ps

module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/ffpa_ctrl.sv
`timescale 1ns / 1ps

module ffpa_ctrl import ffpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  request_t req,
  input  logic     out_free,
  output logic     busy,
  output logic     fin,
  output result_t  res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  request_t          req_r, req_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]  chk_addr_r, chk_addr_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [PAGE_FRAMES-1:0] vld_r, vld_nxt;

  logic               issue;
  logic [ENTRY_W-1:0] rdata;
  logic               ent_used;
  logic [OWNER_W-1:0] ent_owner;
  logic               we;
  logic [ENTRY_W-1:0] wdata;
  logic               take;
  logic               last_chk;

  // Page table: one word per frame
  ffpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGE_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (chk_addr_r),
    .wdata (wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Entry never written since reset reads as free
  assign ent_used  = vld_r[chk_addr_r] & rdata[ENTRY_W-1];
  assign ent_owner = rdata[OWNER_W-1:0];

  assign issue    = (state_r == S_SCAN) && (32'(idx_r) < PAGE_FRAMES);
  assign last_chk = chk_v_r && (32'(chk_addr_r) == PAGE_FRAMES - 1);

  // Per-frame decision on the word just read
  always_comb begin
    take  = 1'b0;
    wdata = '0;
    if (chk_v_r) begin
      if (req_r.cmd == CMD_ALLOC) begin
        take  = !ent_used && (32'(done_r) < 32'(req_r.page_count));
        wdata = {1'b1, req_r.owner_id};
      end else begin
        take  = ent_used && (ent_owner == req_r.owner_id);
        wdata = '0;
      end
    end
  end
  assign we = take;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    idx_nxt      = idx_r;
    chk_v_nxt    = 1'b0;
    chk_addr_nxt = chk_addr_r;
    done_nxt     = done_r;
    mask_nxt     = mask_r;
    vld_nxt      = vld_r;
    fin          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          idx_nxt   = '0;
          done_nxt  = '0;
          mask_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          chk_v_nxt    = 1'b1;
          chk_addr_nxt = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + 1'b1;
        end
        if (take) begin
          vld_nxt[chk_addr_r] = 1'b1;
          done_nxt            = done_r + 1'b1;
          if (32'(chk_addr_r) < MASK_W) begin
            mask_nxt[4'(chk_addr_r)] = 1'b1;
          end
        end
        if (last_chk) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result word
  always_comb begin
    res.page_mask  = mask_r;
    res.pages_done = (32'(done_r) > 31) ? 5'd31 : 5'(done_r);
    if (req_r.cmd == CMD_ALLOC) begin
      if (req_r.page_count == '0 || 32'(done_r) == 32'(req_r.page_count)) begin
        res.status = ST_OK;
      end else begin
        res.status = ST_SHORT;
      end
    end else begin
      res.status = (done_r != '0) ? ST_OK : ST_NOT_FOUND;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chk_v_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= chk_v_nxt;
      vld_r   <= vld_nxt;
    end
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    chk_addr_r <= chk_addr_nxt;
    done_r     <= done_nxt;
    mask_r     <= mask_nxt;
  end

endmodule

### hw/rtl/first_free_page_allocator.sv
`timescale 1ns / 1ps
// First-fit page frame allocator.
// Input channel (in_valid / in_stall): one word holds cmd, owner_id and
// page_count. cmd allocate gives the first free frames in page order to
// owner_id; cmd free releases every frame that owner_id holds.
// Output channel (out_valid / out_stall): one word per request with status,
// pages_done and page_mask of the frames touched.
// Walk: a request walks the whole page table held in a RAM with one read
// and one write port, one frame read per cycle with the read-modify-write
// done in the cycle after each read. One request is worked on at a
// time; in_stall is high from acceptance until the result moves into the
// output register, so a new word is not taken while a walk is under way.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls and a second result is ready, the walk
// holds in its final state until the register empties.
// Reset (rst_n low, synchronous) marks every frame free at once through
// per-frame valid flags; no clearing pass is needed.
module first_free_page_allocator import ffpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [OWNER_W-1:0] in_owner_id,
  input  logic [WANT_W-1:0]  in_page_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [DONE_W-1:0]  out_pages_done,
  output logic [MASK_W-1:0]  out_page_mask
);

  request_t req;
  result_t  res;
  result_t  res_r;
  logic     out_valid_r, out_valid_nxt;
  logic     busy, fin, out_free, start;

  assign req.cmd        = in_cmd;
  assign req.owner_id   = in_owner_id;
  assign req.page_count = in_page_count;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .out_free (out_free),
    .busy     (busy),
    .fin      (fin),
    .res      (res)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (fin) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_r.status;
  assign out_pages_done = res_r.pages_done;
  assign out_page_mask  = res_r.page_mask;

endmodule
